/* hw/rtl/c2e_pkg.sv */
`default_nettype none

package c2e_pkg;

	localparam int YRS_W  = 9;
	localparam int MON_W  = 8;
	localparam int DAY_W  = 9;
	localparam int HOUR_W = 5;
	localparam int MIN_W  = 6;
	localparam int SEC_W  = 6;
	localparam int OUT_W  = 34;

	localparam int OFF_W  = 10;
	localparam int TOD_W  = 17;
	localparam int DAYS_W = 18;

	localparam logic [OUT_W-1:0] SECS_PER_DAY = 34'd86400;

	typedef struct packed {
		logic [DAYS_W-1:0] days;
		logic [TOD_W-1:0]  tod;
	} date_word_t;

	// days before the first of each month, common year
	function automatic logic [8:0] cum_days(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd59;
			4'd3:    r = 9'd90;
			4'd4:    r = 9'd120;
			4'd5:    r = 9'd151;
			4'd6:    r = 9'd181;
			4'd7:    r = 9'd212;
			4'd8:    r = 9'd243;
			4'd9:    r = 9'd273;
			4'd10:   r = 9'd304;
			4'd11:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/calendar_to_epoch_seconds.sv */
// channel  | handshake              | ports
// ---------+------------------------+-----------------------------------------------
// input    | start high, busy low   | years_since_1900, month_count, day_number,
//          |                        | hour_of_day, minute_of_hour, second_of_minute
// result   | done high, one cycle   | epoch_seconds
//
// one word enters every cycle; its result shows on done after six register stages:
// month split, year offset, table and year multiply, day sum,
// day-to-seconds multiply, final add
// arst_n clears the stage valid bits only; no clearing pass
// busy stays low and the receiver cannot stall, so nothing is held back
`default_nettype none

module calendar_to_epoch_seconds
	import c2e_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [YRS_W-1:0]  years_since_1900,
	input  wire logic [MON_W-1:0]  month_count,
	input  wire logic [DAY_W-1:0]  day_number,
	input  wire logic [HOUR_W-1:0] hour_of_day,
	input  wire logic [MIN_W-1:0]  minute_of_hour,
	input  wire logic [SEC_W-1:0]  second_of_minute,
	output logic                   done,
	output logic [OUT_W-1:0]       epoch_seconds
);

	logic       date_valid;
	date_word_t date_word;

	assign busy = 1'b0;

	c2e_date u_date (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (start && !busy),
		.years_since_1900 (years_since_1900),
		.month_count      (month_count),
		.day_number       (day_number),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute),
		.date_valid       (date_valid),
		.date_word        (date_word)
	);

	c2e_secs u_secs (
		.clk           (clk),
		.arst_n        (arst_n),
		.date_valid    (date_valid),
		.date_word     (date_word),
		.done          (done),
		.epoch_seconds (epoch_seconds)
	);

`ifndef SYNTHESIS
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 6))
		else $error("result without an accepted word");

	a_date_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		date_valid |-> ##2 done)
		else $error("word lost in seconds stages");

	a_post_1970_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && years_since_1900 >= 9'd71, 6))
		|-> epoch_seconds >= 34'd31449600)
		else $error("year after 1970 gave too few seconds");
`endif

endmodule

`default_nettype wire

/* hw/rtl/c2e_date.sv */
`default_nettype none

module c2e_date
	import c2e_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [YRS_W-1:0]  years_since_1900,
	input  wire logic [MON_W-1:0]  month_count,
	input  wire logic [DAY_W-1:0]  day_number,
	input  wire logic [HOUR_W-1:0] hour_of_day,
	input  wire logic [MIN_W-1:0]  minute_of_hour,
	input  wire logic [SEC_W-1:0]  second_of_minute,
	output logic                   date_valid,
	output date_word_t             date_word
);

	// stage 1: month carry quotient and time of day
	logic              v_s1;
	logic [4:0]        qm_s1;
	logic [MON_W-1:0]  mon_s1;
	logic [YRS_W-1:0]  yrs_s1;
	logic [DAY_W-1:0]  day_s1;
	logic [TOD_W-1:0]  tod_s1;
	logic [15:0]       mon_x171;

	assign mon_x171 = 16'(month_count) * 16'd171;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		qm_s1  <= mon_x171[15:11];
		mon_s1 <= month_count;
		yrs_s1 <= years_since_1900;
		day_s1 <= day_number;
		tod_s1 <= TOD_W'(hour_of_day) * 17'd3600 + TOD_W'(minute_of_hour) * 17'd60
			+ TOD_W'(second_of_minute);
	end

	// stage 2: year offset and month within year
	logic              v_s2;
	logic [OFF_W-1:0]  off_s2;
	logic [3:0]        rem_s2;
	logic [DAY_W-1:0]  day_s2;
	logic [TOD_W-1:0]  tod_s2;
	logic [MON_W-1:0]  rem_full;

	assign rem_full = mon_s1 - MON_W'(8'(qm_s1) * 8'd12);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		off_s2 <= OFF_W'(yrs_s1) + OFF_W'(qm_s1);
		rem_s2 <= rem_full[3:0];
		day_s2 <= day_s1;
		tod_s2 <= tod_s1;
	end

	// stage 3: month days, year days, century count
	logic              v_s3;
	logic [9:0]        cum_s3;
	logic [DAYS_W-1:0] yd_s3;
	logic [OFF_W-1:0]  a_s3;
	logic [3:0]        q100_s3;
	logic              post70_s3;
	logic [DAY_W-1:0]  day_s3;
	logic [TOD_W-1:0]  tod_s3;
	logic              leap;
	logic [OFF_W-1:0]  a_next;
	logic [15:0]       a_x41;
	logic [OFF_W-1:0]  ydiff;

	// offset from 1900: centuries 1900, 2100, 2200, 2300 are common years
	assign leap = (off_s2[1:0] == 2'd0) && !(off_s2 == 10'd0 || off_s2 == 10'd200
		|| off_s2 == 10'd300 || off_s2 == 10'd400);
	// year minus 1601
	assign a_next = off_s2 + 10'd299;
	assign a_x41  = 16'(a_next) * 16'd41;
	assign ydiff  = off_s2 - 10'd70;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		cum_s3    <= 10'(cum_days(rem_s2)) + 10'(leap && (rem_s2 >= 4'd2));
		yd_s3     <= DAYS_W'(ydiff) * 18'd365;
		a_s3      <= a_next;
		q100_s3   <= a_x41[15:12];
		post70_s3 <= off_s2 > 10'd70;
		day_s3    <= day_s2;
		tod_s3    <= tod_s2;
	end

	// stage 4: total day count
	logic              v_s4;
	date_word_t        word_s4;
	logic [DAYS_W-1:0] leaps;
	logic [DAYS_W-1:0] ydays;

	assign leaps = DAYS_W'(a_s3[OFF_W-1:2]) - DAYS_W'(q100_s3) + DAYS_W'(q100_s3[3:2])
		- 18'd89;
	assign ydays = post70_s3 ? (yd_s3 + leaps) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		word_s4.days <= ydays + DAYS_W'(cum_s3) + DAYS_W'(day_s3);
		word_s4.tod  <= tod_s3;
	end

	assign date_valid = v_s4;
	assign date_word  = word_s4;

endmodule

`default_nettype wire

/* hw/rtl/c2e_secs.sv */
`default_nettype none

module c2e_secs
	import c2e_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             date_valid,
	input  wire date_word_t       date_word,
	output logic                  done,
	output logic [OUT_W-1:0]      epoch_seconds
);

	// stage 5: whole days to seconds
	logic             v_s5;
	logic             zero_s5;
	logic [OUT_W-1:0] prod_s5;
	logic [TOD_W-1:0] tod_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= date_valid;
		end
	end

	always_ff @(posedge clk) begin
		zero_s5 <= date_word.days == '0;
		prod_s5 <= OUT_W'(DAYS_W'(date_word.days - 18'd1)) * SECS_PER_DAY;
		tod_s5  <= date_word.tod;
	end

	// stage 6: add time of day, clamp at zero for day zero
	logic             v_s6;
	logic [OUT_W-1:0] secs_s6;
	logic [OUT_W-1:0] tod_ext;

	assign tod_ext = OUT_W'(tod_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (zero_s5) begin
			secs_s6 <= (tod_ext >= SECS_PER_DAY) ? (tod_ext - SECS_PER_DAY) : '0;
		end else begin
			secs_s6 <= prod_s5 + tod_ext;
		end
	end

	assign done          = v_s6;
	assign epoch_seconds = secs_s6;

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import c2e_pkg::*;

	localparam int BASE_YEAR  = 1900;
	localparam int EPOCH_YEAR = 1970;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 12;

	typedef struct packed {
		logic [YRS_W-1:0]  yrs;
		logic [MON_W-1:0]  mon;
		logic [DAY_W-1:0]  day;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  min;
		logic [SEC_W-1:0]  sec;
	} date_in_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [YRS_W-1:0]  years_since_1900 = '0;
	logic [MON_W-1:0]  month_count = '0;
	logic [DAY_W-1:0]  day_number = '0;
	logic [HOUR_W-1:0] hour_of_day = '0;
	logic [MIN_W-1:0]  minute_of_hour = '0;
	logic [SEC_W-1:0]  second_of_minute = '0;
	logic              done;
	logic [OUT_W-1:0]  epoch_seconds;

	logic [OUT_W-1:0] pending_seconds [$];
	int               errors = 0;
	int               quiet_cycles = 0;
	bit               gaps_on = 1'b0;

	calendar_to_epoch_seconds dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.years_since_1900 (years_since_1900),
		.month_count      (month_count),
		.day_number       (day_number),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute),
		.done             (done),
		.epoch_seconds    (epoch_seconds)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// common-year month lengths
	function automatic int month_days(input int m);
		case (m)
			1:             return 28;
			3, 5, 8, 10:   return 30;
			default:       return 31;
		endcase
	endfunction

	function automatic int unsigned leap_count(input int unsigned y);
		return y / 4 - y / 100 + y / 400;
	endfunction

	function automatic logic [OUT_W-1:0] epoch_of(input date_in_t w);
		int unsigned year;
		int unsigned month_in_year;
		int unsigned days;
		bit          leap;
		longint      total;
		year = BASE_YEAR + w.yrs + w.mon / 12;
		month_in_year = w.mon % 12;
		days = 0;
		if (year > EPOCH_YEAR)
			days = 365 * (year - EPOCH_YEAR) + leap_count(year - 1) - leap_count(EPOCH_YEAR - 1);
		leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
		for (int i = 0; i < month_in_year; i++)
			days += month_days(i) + ((leap && i == 1) ? 1 : 0);
		days += w.day;
		total = longint'(days) - 1;
		total = total * 24 + longint'(w.hour);
		total = total * 60 + longint'(w.min);
		total = total * 60 + longint'(w.sec);
		if (total < 0)
			total = 0;
		return total[OUT_W-1:0];
	endfunction

	function automatic date_in_t mk(input int y, input int m, input int d, input int h,
			input int mi, input int s);
		date_in_t w;
		w.yrs = YRS_W'(y);
		w.mon = MON_W'(m);
		w.day = DAY_W'(d);
		w.hour = HOUR_W'(h);
		w.min = MIN_W'(mi);
		w.sec = SEC_W'(s);
		return w;
	endfunction

	function automatic date_in_t rand_word(input bit wild);
		date_in_t w;
		w = mk($urandom_range(511), $urandom_range(255), $urandom_range(511),
			$urandom_range(31), $urandom_range(63), $urandom_range(63));
		if (!wild) begin
			if ($urandom_range(9) != 0)
				w.mon = MON_W'($urandom_range(11));
			if (w.mon == 0 && $urandom_range(1))
				w.day = DAY_W'($urandom_range(366, 1));
			else
				w.day = DAY_W'($urandom_range(31, 1));
			w.hour = HOUR_W'($urandom_range(23));
			w.min = MIN_W'($urandom_range(59));
			w.sec = SEC_W'($urandom_range(60));
		end
		return w;
	endfunction

	task automatic put_word(input date_in_t w);
		years_since_1900 <= w.yrs;
		month_count <= w.mon;
		day_number <= w.day;
		hour_of_day <= w.hour;
		minute_of_hour <= w.min;
		second_of_minute <= w.sec;
	endtask

	task automatic send_word(input date_in_t w);
		int gap;
		gap = 0;
		while (gaps_on && $urandom_range(99) < 27)
			gap++;
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
			put_word(rand_word(1'b1));
		end
		@(negedge clk);
		start <= 1'b1;
		put_word(w);
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_seconds.size() != 0)
			@(posedge clk);
	endtask

	// accept and check at the same edge; push first so a same-cycle result still matches
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				pending_seconds.push_back(epoch_of(mk(int'(years_since_1900),
					int'(month_count), int'(day_number), int'(hour_of_day),
					int'(minute_of_hour), int'(second_of_minute))));
			if (done) begin
				if (pending_seconds.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual epoch_seconds %0d",
						$time, epoch_seconds);
					errors++;
				end else begin
					logic [OUT_W-1:0] want;
					want = pending_seconds.pop_front();
					if (epoch_seconds !== want) begin
						$display("%0t: epoch_seconds expected %0d actual %0d",
							$time, want, epoch_seconds);
						errors++;
					end
				end
			end
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic test_corners();
		send_word(mk(0, 0, 0, 0, 0, 0));
		send_word(mk(511, 255, 511, 31, 63, 63));
		send_word(mk(70, 0, 1, 0, 0, 0));
		send_word(mk(69, 11, 31, 23, 59, 59));
		send_word(mk(69, 12, 1, 0, 0, 1));
		send_word(mk(70, 0, 0, 23, 59, 59));
		send_word(mk(70, 0, 0, 31, 63, 63));
		send_word(mk(0, 0, 0, 31, 63, 63));
		send_word(mk(100, 1, 29, 12, 0, 0));
		send_word(mk(100, 2, 1, 0, 0, 0));
		send_word(mk(200, 2, 1, 0, 0, 0));
		send_word(mk(500, 2, 1, 0, 0, 0));
		send_word(mk(104, 0, 366, 23, 59, 60));
		send_word(mk(105, 0, 365, 23, 59, 59));
		send_word(mk(116, 12, 31, 0, 0, 0));
		send_word(mk(511, 11, 31, 23, 59, 60));
		send_word(mk(0, 255, 1, 0, 0, 0));
		send_word(mk(138, 0, 19, 3, 14, 7));
		send_word(mk(123, 5, 0, 0, 0, 0));
		send_word(mk(50, 6, 15, 8, 30, 30));
		wait_drained();
	endtask

	task automatic test_random_dates(input int count, input bit with_gaps);
		gaps_on = with_gaps;
		for (int n = 0; n < count; n++)
			send_word(rand_word($urandom_range(99) < 20));
	endtask

	task automatic test_pause_refill();
		gaps_on = 1'b1;
		for (int n = 0; n < 30; n++)
			send_word(rand_word(1'b0));
		wait_drained();
		for (int n = 0; n < 30; n++)
			send_word(rand_word(1'b0));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_corners();
		test_random_dates(200, 1'b0);
		test_random_dates(390, 1'b1);
		test_pause_refill();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending_seconds.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/c2e_pkg.sv
hw/rtl/c2e_date.sv
hw/rtl/c2e_secs.sv
hw/rtl/calendar_to_epoch_seconds.sv
tb/testbench.sv
